FILE: hw/rtl/b64d_pkg.sv
// Shared types, constants and the character classifier for the base64 stream decoder.
package b64d_pkg;

   // Width of the decoded length field on the result channel.
   localparam int unsigned LEN_OUT_W = 24;

   // Depth of the result queue and its pointer and fill-count widths.
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_PTR_W = 2;
   localparam int unsigned Q_CNT_W = 3;

   // Classifier codes outside the 0..63 sextet range.
   localparam logic [7:0] CODE_PAD   = 8'd64;
   localparam logic [7:0] CODE_SPACE = 8'hFE;
   localparam logic [7:0] CODE_BAD   = 8'hFF;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_OK   = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   // One result transaction.
   typedef struct packed {
      kind_type             kind;
      logic [7:0]           data_byte;
      logic [LEN_OUT_W-1:0] decoded_length;
   } rsp_entry_type;

   // Results that one input transaction produces, in delivery order.
   typedef struct packed {
      logic [1:0]    count;
      rsp_entry_type first;
      rsp_entry_type second;
   } core_out_type;

   // Map one character to its sextet value or to a special code.
   function automatic logic [7:0] classify(input logic [7:0] c);
      logic [7:0] code;
      case (c) inside
         [8'h41:8'h5A]: code = c - 8'h41;
         [8'h61:8'h7A]: code = c - 8'h61 + 8'd26;
         [8'h30:8'h39]: code = c - 8'h30 + 8'd52;
         8'h2B:         code = 8'd62;
         8'h2F:         code = 8'd63;
         8'h3D:         code = CODE_PAD;
         8'h20, 8'h09, 8'h0D, 8'h0A: code = CODE_SPACE;
         default:       code = CODE_BAD;
      endcase
      return code;
   endfunction

endpackage

FILE: hw/rtl/b64d_core.sv
// Decode state and per-character logic of the base64 stream decoder.
module b64d_core
   import b64d_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  logic         char_present,
   input  logic [7:0]   ch,
   input  logic         end_of_stream,
   output core_out_type results
);

   localparam int unsigned EXT_W = (LENGTH_BITS > LEN_OUT_W) ? LENGTH_BITS : LEN_OUT_W;

   logic [11:0]            acc_ff, acc_in;
   logic [3:0]             pend_ff, pend_in;
   logic [1:0]             pad_ff, pad_in;
   logic                   err_ff, err_in;
   logic [LENGTH_BITS-1:0] cnt_ff, cnt_in;

   logic [7:0]       code;
   logic [3:0]       pend_sum;
   logic [11:0]      acc_shift;
   logic             byte_out;
   logic [7:0]       byte_val;
   logic             end_bad;
   logic [EXT_W-1:0] cnt_ext;
   rsp_entry_type    data_entry;
   rsp_entry_type    end_entry;

   assign code = classify(ch);

   // Character handling: update the accumulator and decide on a data byte.
   always_comb begin
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      pad_in    = pad_ff;
      err_in    = err_ff;
      cnt_in    = cnt_ff;
      byte_out  = 1'b0;
      pend_sum  = pend_ff + 4'd6;
      acc_shift = 12'd0;
      byte_val  = 8'd0;
      if (char_present && !err_ff) begin
         if (code == CODE_SPACE) begin
            // Whitespace is skipped.
         end else if (code == CODE_BAD) begin
            err_in = 1'b1;
         end else if (code == CODE_PAD) begin
            if (pad_ff != 2'd3) begin
               pad_in = pad_ff + 2'd1;
            end
         end else if (pad_ff != 2'd0) begin
            err_in = 1'b1;
         end else begin
            acc_in  = {acc_ff[5:0], code[5:0]};
            pend_in = pend_sum;
            if (pend_sum >= 4'd8) begin
               pend_in   = pend_sum - 4'd8;
               acc_shift = acc_in >> pend_in;
               byte_val  = acc_shift[7:0];
               byte_out  = 1'b1;
               if (cnt_ff != '1) begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
      end
   end

   // End-of-stream verdict uses the state after this character.
   assign end_bad = err_in || (pad_in > 2'd2) || (pend_in >= 4'd6);
   assign cnt_ext = EXT_W'(cnt_in);

   always_comb begin
      data_entry.kind           = KIND_DATA;
      data_entry.data_byte      = byte_val;
      data_entry.decoded_length = '0;
      end_entry.kind            = end_bad ? KIND_ERR : KIND_OK;
      end_entry.data_byte       = 8'd0;
      end_entry.decoded_length  = end_bad ? '0 : cnt_ext[LEN_OUT_W-1:0];
   end

   // Order the results: the data byte first, then the end report.
   always_comb begin
      results.count  = {1'b0, byte_out} + {1'b0, end_of_stream};
      results.first  = byte_out ? data_entry : end_entry;
      results.second = end_entry;
   end

   // State registers; the end of a stream returns everything to zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= '0;
         pad_ff  <= '0;
         err_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else if (fire) begin
         if (end_of_stream) begin
            acc_ff  <= '0;
            pend_ff <= '0;
            pad_ff  <= '0;
            err_ff  <= 1'b0;
            cnt_ff  <= '0;
         end else begin
            acc_ff  <= acc_in;
            pend_ff <= pend_in;
            pad_ff  <= pad_in;
            err_ff  <= err_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

   // The pending bit count only ever takes the values 0, 2, 4 or 6.
   a_pend_even: assert property (@(posedge clock) disable iff (reset)
      (pend_ff[0] == 1'b0) && (pend_ff <= 4'd6))
      else $error("pending bit count out of range");

   // A stream end leaves the decoder fully cleared.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && end_of_stream) |=>
         (acc_ff == '0) && (pend_ff == '0) && (pad_ff == '0) && !err_ff && (cnt_ff == '0))
      else $error("state not cleared after stream end");

   // No data byte is produced once an error has been seen.
   a_no_data_after_err: assert property (@(posedge clock) disable iff (reset)
      (fire && err_ff) |-> !byte_out)
      else $error("data byte after error");

endmodule

FILE: hw/rtl/base64_stream_decoder.sv
// Top level of the base64 stream decoder: input register, decoder core, result queue.
//
// Usage: the req_ channel carries one transaction per character: req_char_present
// says whether req_ch holds a character, and req_end_of_stream marks the last
// transaction of a stream (it may carry a character too, or none). Each
// transaction yields zero, one or two rsp_ transactions: a decoded data byte
// (rsp_kind data) as soon as eight bits are collected, and, on the stream end,
// a report of success with rsp_decoded_length or of error.
// A request passes the input register and the decode logic into the result
// queue, which registers each result before rsp_ offers it. Throughput: one
// request transaction per cycle while req_stall is low; the result channel
// takes one transaction per cycle, so transactions that yield two results can
// fill the four-entry result queue and raise req_stall.
// Reset clears the decoder state, the input register and the queue; the first
// stream starts fresh. When the receiver asserts rsp_stall the queue fills, then
// the input register holds, and req_stall rises; nothing is dropped.
module base64_stream_decoder
   import b64d_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_char_present,
   input  logic [7:0]           req_ch,
   input  logic                 req_end_of_stream,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_kind,
   output logic [7:0]           rsp_data_byte,
   output logic [LEN_OUT_W-1:0] rsp_decoded_length
);

   logic         stage_valid_ff, stage_valid_in;
   logic         stage_char_ff;
   logic [7:0]   stage_ch_ff;
   logic         stage_last_ff;
   logic         stage_go;
   logic         req_take;
   core_out_type core_out;

   rsp_entry_type      q_mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_p1;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] q_cnt_ff, q_cnt_in;
   logic [1:0]         push_n;
   logic               pop;
   rsp_entry_type      head;

   // Input register moves into the queue when two slots are free.
   assign stage_go  = stage_valid_ff && (q_cnt_ff <= Q_CNT_W'(Q_DEPTH - 2));
   assign req_stall = stage_valid_ff && !stage_go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_take) begin
         stage_valid_in = 1'b1;
      end else if (stage_go) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_char_ff <= req_char_present;
         stage_ch_ff   <= req_ch;
         stage_last_ff <= req_end_of_stream;
      end
   end

   // Decoder state and per-character logic.
   b64d_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (stage_go),
      .char_present  (stage_char_ff),
      .ch            (stage_ch_ff),
      .end_of_stream (stage_last_ff),
      .results       (core_out)
   );

   // Result queue: up to two pushes and one pop per cycle.
   assign push_n    = stage_go ? core_out.count : 2'd0;
   assign pop       = rsp_valid && !rsp_stall;
   assign wr_ptr_p1 = wr_ptr_ff + 1'b1;
   assign wr_ptr_in = wr_ptr_ff + push_n[Q_PTR_W-1:0];
   assign rd_ptr_in = pop ? (rd_ptr_ff + 1'b1) : rd_ptr_ff;
   assign q_cnt_in  = q_cnt_ff + Q_CNT_W'(push_n) - Q_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         q_mem_ff[wr_ptr_ff] <= core_out.first;
      end
      if (push_n == 2'd2) begin
         q_mem_ff[wr_ptr_p1] <= core_out.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   // Result channel shows the queue head.
   assign head               = q_mem_ff[rd_ptr_ff];
   assign rsp_valid          = (q_cnt_ff != '0);
   assign rsp_kind           = head.kind;
   assign rsp_data_byte      = head.data_byte;
   assign rsp_decoded_length = head.decoded_length;

   // The queue never holds more than its depth.
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("result queue overflow");

   // A stream end always produces at least one result.
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      (stage_go && stage_last_ff) |-> (push_n != 2'd0))
      else $error("stream end without a result");

   // The pointer distance tracks the fill count.
   a_q_ptrs: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == q_cnt_ff[Q_PTR_W-1:0])
      else $error("queue pointers disagree with fill count");

endmodule
